[src/bcsat_pkg.sv]
// Package for the bitcrusher / soft clip / wet-dry mixer.
// Sample and amount formats, register codes, stage control types and the tanh
// table generator. No dependencies.
package bcsat_pkg;

  localparam int SAMPLE_WIDTH     = 24;
  localparam int TANH_TABLE_DEPTH = 256;
  localparam int TANH_DEPTH_LOG2  = $clog2(TANH_TABLE_DEPTH);
  // table covers |x| in [0, 2^TANH_X_LOG2)
  localparam int TANH_X_LOG2      = 3;
  localparam int TANH_X_MAX       = 1 << TANH_X_LOG2;
  localparam int TAYLOR_TERMS     = 16;
  localparam int FRAC_W           = 16;
  // step of 2x (the exp(-2x) argument) between table points, Q32
  localparam longint unsigned TANH_STEP_Q32 =
    ((64'd2 * TANH_X_MAX) << 32) / TANH_TABLE_DEPTH;

  localparam int AMT_W            = 9;
  localparam int AMT_FRAC         = 8;
  localparam logic [AMT_W-1:0] AMT_ONE = AMT_W'(1 << AMT_FRAC);
  localparam int DRIVE_GAIN       = 5;

  localparam int BIT_DEPTH_W      = 5;
  localparam int BIT_DEPTH_RESET  = SAMPLE_WIDTH;

  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = AMT_W;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]          cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_DEPTH  = 2'd0,
    REG_SAT_AMOUNT = 2'd1,
    REG_WET_AMOUNT = 2'd2
  } cfg_reg_t;

  // load enables of the two blend stages
  typedef struct packed {
    logic prod_ld;
    logic sum_ld;
  } blend_ld_t;

  // restoring shift/subtract quotient, elaboration only
  function automatic longint unsigned udiv_u64(input longint unsigned n,
                                               input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(pt * TANH_X_MAX / DEPTH) in Q1.(SAMPLE_WIDTH-1), as (1-e)/(1+e) with
  // e = exp(-2x) in Q0.32 built from a truncated Taylor step factor.
  // Evaluated at elaboration only.
  function automatic logic [SAMPLE_WIDTH-1:0] tanh_entry(input int unsigned pt);
    longint unsigned one;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    int k;
    int unsigned j;
    one  = 64'd1 << 32;
    term = one;
    sum  = 64'd0;
    e    = one;
    for (k = 0; k < TAYLOR_TERMS; k++) begin
      if (k[0]) sum = sum - term;
      else      sum = sum + term;
      term = udiv_u64(term * TANH_STEP_Q32, 64'(k + 1) << 32);
    end
    for (j = 0; j < pt; j++) begin
      e = (e * sum + (64'd1 << 31)) >> 32;
    end
    num = (one - e) << (SAMPLE_WIDTH - 1);
    den = one + e;
    q   = udiv_u64(num + (den >> 1), den);
    return q[SAMPLE_WIDTH-1:0];
  endfunction

  localparam logic [SAMPLE_WIDTH-1:0] TANH_LAST = tanh_entry(TANH_TABLE_DEPTH);

endpackage

[src/bcsat_if.sv]
// Valid/ready channel interfaces: sample pair in, result pair out, register writes.
// Depends on bcsat_pkg.
interface bcsat_in_if import bcsat_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t dry_sample;
  sample_t wet_sample;
  modport source (output valid, dry_sample, wet_sample, input ready);
  modport sink   (input valid, dry_sample, wet_sample, output ready);
endinterface

interface bcsat_out_if import bcsat_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t wet_out;
  sample_t mixed_out;
  modport source (output valid, wet_out, mixed_out, input ready);
  modport sink   (input valid, wet_out, mixed_out, output ready);
endinterface

interface bcsat_cfg_if import bcsat_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/bcsat_tanh_lut.sv]
// Constant tanh table: base value and slope to the next entry for each segment.
// Depends on bcsat_pkg (tanh_entry, evaluated at elaboration).
module bcsat_tanh_lut import bcsat_pkg::*; (
  input  logic [TANH_DEPTH_LOG2-1:0] idx,
  output logic [SAMPLE_WIDTH-1:0]    lo,
  output logic [SAMPLE_WIDTH-1:0]    diff
);

  logic [SAMPLE_WIDTH-1:0] lo_tab   [TANH_TABLE_DEPTH];
  logic [SAMPLE_WIDTH-1:0] diff_tab [TANH_TABLE_DEPTH];

  for (genvar g = 0; g < TANH_TABLE_DEPTH; g++) begin : g_seg
    localparam logic [SAMPLE_WIDTH-1:0] LO_G   = tanh_entry(g);
    localparam logic [SAMPLE_WIDTH-1:0] HI_G   = tanh_entry(g + 1);
    localparam logic [SAMPLE_WIDTH-1:0] DIFF_G = (HI_G >= LO_G) ? HI_G - LO_G : '0;
    assign lo_tab[g]   = LO_G;
    assign diff_tab[g] = DIFF_G;
  end

  assign lo   = lo_tab[idx];
  assign diff = diff_tab[idx];

endmodule

[src/bcsat_blend.sv]
// Two-stage crossfade (a*(1-w) + b*w), rounded to nearest and saturated.
// Stage one registers both products, stage two sums, rounds and clamps.
// Depends on bcsat_pkg.
module bcsat_blend import bcsat_pkg::*; (
  input  logic             clk,
  input  blend_ld_t        ld,
  input  sample_t          a_in,
  input  sample_t          b_in,
  input  logic [AMT_W-1:0] w_in,
  output sample_t          res_out
);

  localparam int PW = SAMPLE_WIDTH + AMT_W + 1;
  localparam int SW = PW + 1 - AMT_FRAC;
  localparam logic signed [PW:0] RND_HALF = (PW+1)'(1 << (AMT_FRAC - 1));

  logic [AMT_W-1:0]     inv_w;
  logic signed [PW-1:0] prod_a_nxt, prod_b_nxt;
  logic signed [PW-1:0] prod_a_r, prod_b_r;
  logic signed [PW:0]   sum_nxt;
  logic signed [SW-1:0] shr;
  sample_t              res_nxt;
  sample_t              res_r;

  always_comb begin
    inv_w      = AMT_ONE - w_in;
    prod_a_nxt = PW'(a_in) * PW'(signed'({1'b0, inv_w}));
    prod_b_nxt = PW'(b_in) * PW'(signed'({1'b0, w_in}));
  end

  always_comb begin
    sum_nxt = (PW+1)'(prod_a_r) + (PW+1)'(prod_b_r) + RND_HALF;
    shr     = SW'(sum_nxt >>> AMT_FRAC);
    if (shr > SW'(SAMPLE_MAX))      res_nxt = SAMPLE_MAX;
    else if (shr < SW'(SAMPLE_MIN)) res_nxt = SAMPLE_MIN;
    else                            res_nxt = shr[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld.prod_ld) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
    end
    if (ld.sum_ld) begin
      res_r <= res_nxt;
    end
  end

  assign res_out = res_r;

endmodule

[src/bitcrush_saturate_wet_dry_mix.sv]
// Bitcrusher with tanh soft clip and wet/dry mixer, signed Q1.23 audio.
// Depends on bcsat_pkg, bcsat_if, bcsat_tanh_lut and bcsat_blend.
//
// One sample pair is taken per clock while the output is not stalled, and there
// is no state between samples. The nine register stages are:
// crush, drive multiply, tanh table read, slope multiply, interpolate and sign,
// two stages of saturation blend, two stages of the wet/dry mix. Every stage
// holds its own valid bit and loads whenever it is empty or its successor
// loads, so a stalled output fills internal bubbles before the input stalls.
// The tanh table is a constant built at elaboration. Registers are written at
// any time through the config channel (always ready) and affect in-flight
// samples before their stage, so write them only while the block is empty.
module bitcrush_saturate_wet_dry_mix import bcsat_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bcsat_in_if.sink     in_chan,
  bcsat_out_if.source  out_chan,
  bcsat_cfg_if.sink    cfg_chan
);

  localparam int NSTG       = 9;
  localparam int SHIFT_W    = $clog2(SAMPLE_WIDTH);
  localparam int DRIVE_MAX  = int'(AMT_ONE) * (1 + DRIVE_GAIN);
  localparam int DRIVE_W    = $clog2(DRIVE_MAX + 1);
  localparam int DPROD_W    = SAMPLE_WIDTH + DRIVE_W;
  localparam int DM_W       = DPROD_W - AMT_FRAC;
  localparam int POS_W      = DM_W + TANH_DEPTH_LOG2;
  localparam int POS_FRAC_W = SAMPLE_WIDTH - 1 + TANH_X_LOG2;
  localparam int IDX_W      = POS_W - POS_FRAC_W;
  localparam int IPROD_W    = SAMPLE_WIDTH + FRAC_W;
  localparam logic [IPROD_W:0] FRAC_HALF = (IPROD_W+1)'(1 << (FRAC_W - 1));

  // ---------------- configuration ----------------
  logic [BIT_DEPTH_W-1:0] bit_depth_r;
  logic [AMT_W-1:0]       sat_amt_r, wet_amt_r;
  logic [AMT_W-1:0]       sat_a, wet_a;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_depth_r <= BIT_DEPTH_W'(BIT_DEPTH_RESET);
      sat_amt_r   <= '0;
      wet_amt_r   <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_reg_t'(cfg_chan.index))
        REG_BIT_DEPTH:  bit_depth_r <= cfg_chan.data[BIT_DEPTH_W-1:0];
        REG_SAT_AMOUNT: sat_amt_r   <= cfg_chan.data[AMT_W-1:0];
        REG_WET_AMOUNT: wet_amt_r   <= cfg_chan.data[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  assign sat_a = (sat_amt_r > AMT_ONE) ? AMT_ONE : sat_amt_r;
  assign wet_a = (wet_amt_r > AMT_ONE) ? AMT_ONE : wet_amt_r;

  // ---------------- stage control ----------------
  logic [NSTG:1] vld_r, vld_nxt, ld;

  always_comb begin
    ld[NSTG] = !vld_r[NSTG] || out_chan.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
    vld_nxt[1] = ld[1] ? in_chan.valid : vld_r[1];
    for (int k = 2; k <= NSTG; k++) begin
      vld_nxt[k] = ld[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_chan.ready  = ld[1];
  assign out_chan.valid = vld_r[NSTG];

  // ---------------- stage 1: crush ----------------
  logic [BIT_DEPTH_W-1:0]       bd_eff;
  logic                         crush_bypass;
  logic [SHIFT_W-1:0]           crush_sh;
  logic signed [SAMPLE_WIDTH:0] crush_half, crush_mask, crush_sum, crush_q;
  sample_t                      y1_nxt;
  sample_t                      s1_y_r, s1_dry_r;

  always_comb begin
    bd_eff       = (bit_depth_r == '0) ? BIT_DEPTH_W'(1) : bit_depth_r;
    crush_bypass = (bd_eff >= BIT_DEPTH_W'(SAMPLE_WIDTH));
    crush_sh     = SHIFT_W'(SAMPLE_WIDTH) - SHIFT_W'(bd_eff);
    crush_half   = (SAMPLE_WIDTH+1)'(1) << (crush_sh - SHIFT_W'(1));
    crush_mask   = {(SAMPLE_WIDTH+1){1'b1}} << crush_sh;
    crush_sum    = (SAMPLE_WIDTH+1)'(in_chan.wet_sample) + crush_half;
    crush_q      = crush_sum & crush_mask;
    // rounding can only overflow upward; floor keeps the bottom in range
    if (crush_bypass)                                y1_nxt = in_chan.wet_sample;
    else if (crush_q > (SAMPLE_WIDTH+1)'(SAMPLE_MAX)) y1_nxt = SAMPLE_MAX;
    else                                             y1_nxt = crush_q[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_y_r   <= y1_nxt;
      s1_dry_r <= in_chan.dry_sample;
    end
  end

  // ---------------- stage 2: driven magnitude ----------------
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [DRIVE_W-1:0]      drive;
  logic [DPROD_W-1:0]      drive_prod;
  logic [DM_W-1:0]         s2_dm_r;
  logic                    s2_neg_r;
  sample_t                 s2_y_r, s2_dry_r;

  always_comb begin
    mag        = s1_y_r[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-s1_y_r) : SAMPLE_WIDTH'(s1_y_r);
    drive      = DRIVE_W'(AMT_ONE) + DRIVE_W'(DRIVE_GAIN) * DRIVE_W'(sat_a);
    drive_prod = DPROD_W'(mag) * DPROD_W'(drive);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_dm_r  <= drive_prod[DPROD_W-1:AMT_FRAC];
      s2_neg_r <= s1_y_r[SAMPLE_WIDTH-1];
      s2_y_r   <= s1_y_r;
      s2_dry_r <= s1_dry_r;
    end
  end

  // ---------------- stage 3: table read ----------------
  logic [POS_W-1:0]           pos;
  logic [IDX_W-1:0]           seg_idx;
  logic                       seg_over;
  logic [SAMPLE_WIDTH-1:0]    lut_lo, lut_diff;
  logic [SAMPLE_WIDTH-1:0]    s3_lo_r, s3_diff_r;
  logic [FRAC_W-1:0]          s3_frac_r;
  logic                       s3_neg_r;
  sample_t                    s3_y_r, s3_dry_r;

  always_comb begin
    pos      = {s2_dm_r, {TANH_DEPTH_LOG2{1'b0}}};
    seg_idx  = pos[POS_W-1:POS_FRAC_W];
    seg_over = (seg_idx >= IDX_W'(TANH_TABLE_DEPTH));
  end

  bcsat_tanh_lut u_lut (
    .idx  (seg_idx[TANH_DEPTH_LOG2-1:0]),
    .lo   (lut_lo),
    .diff (lut_diff)
  );

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_lo_r   <= seg_over ? TANH_LAST : lut_lo;
      s3_diff_r <= seg_over ? '0 : lut_diff;
      s3_frac_r <= pos[POS_FRAC_W-1 -: FRAC_W];
      s3_neg_r  <= s2_neg_r;
      s3_y_r    <= s2_y_r;
      s3_dry_r  <= s2_dry_r;
    end
  end

  // ---------------- stage 4: slope times fraction ----------------
  logic [IPROD_W-1:0]      s4_prod_r;
  logic [SAMPLE_WIDTH-1:0] s4_lo_r;
  logic                    s4_neg_r;
  sample_t                 s4_y_r, s4_dry_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_prod_r <= IPROD_W'(s3_diff_r) * IPROD_W'(s3_frac_r);
      s4_lo_r   <= s3_lo_r;
      s4_neg_r  <= s3_neg_r;
      s4_y_r    <= s3_y_r;
      s4_dry_r  <= s3_dry_r;
    end
  end

  // ---------------- stage 5: interpolate, restore sign ----------------
  logic [IPROD_W:0]         interp_rnd;
  logic [SAMPLE_WIDTH+1:0]  t_sum;
  logic [SAMPLE_WIDTH-1:0]  t_clamp;
  sample_t                  st_nxt;
  sample_t                  s5_st_r, s5_y_r, s5_dry_r;

  always_comb begin
    interp_rnd = {1'b0, s4_prod_r} + FRAC_HALF;
    t_sum      = (SAMPLE_WIDTH+2)'(s4_lo_r) + (SAMPLE_WIDTH+2)'(interp_rnd[IPROD_W:FRAC_W]);
    t_clamp    = (t_sum > (SAMPLE_WIDTH+2)'(SAMPLE_MAX)) ? SAMPLE_MAX : t_sum[SAMPLE_WIDTH-1:0];
    st_nxt     = s4_neg_r ? -signed'(t_clamp) : signed'(t_clamp);
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_st_r  <= st_nxt;
      s5_y_r   <= s4_y_r;
      s5_dry_r <= s4_dry_r;
    end
  end

  // ---------------- stages 6-7: saturation blend ----------------
  // with zero amount the blend returns the crushed sample unchanged
  sample_t clip_y;
  sample_t s6_dry_r, s7_dry_r;

  bcsat_blend u_clip_blend (
    .clk     (clk),
    .ld      ('{prod_ld: ld[6], sum_ld: ld[7]}),
    .a_in    (s5_y_r),
    .b_in    (s5_st_r),
    .w_in    (sat_a),
    .res_out (clip_y)
  );

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s6_dry_r <= s5_dry_r;
    end
    if (ld[7]) begin
      s7_dry_r <= s6_dry_r;
    end
  end

  // ---------------- stages 8-9: wet/dry mix ----------------
  sample_t mix_res;
  sample_t s8_y_r, s9_y_r;

  bcsat_blend u_mix_blend (
    .clk     (clk),
    .ld      ('{prod_ld: ld[8], sum_ld: ld[9]}),
    .a_in    (s7_dry_r),
    .b_in    (clip_y),
    .w_in    (wet_a),
    .res_out (mix_res)
  );

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      s8_y_r <= clip_y;
    end
    if (ld[9]) begin
      s9_y_r <= s8_y_r;
    end
  end

  assign out_chan.wet_out   = s9_y_r;
  assign out_chan.mixed_out = mix_res;

endmodule
